// ===== sv/glcs_pkg.sv =====
// glcs_pkg: shared constants, types and command codes for the grid search unit
// no dependencies
`default_nettype none
package glcs_pkg;
    localparam int GRID_SIDE_DEF   = 64;
    localparam int WINDOW_HALF_DEF = 5;

    localparam logic [7:0] LOAD_CAP_RST = 8'd73;
    localparam logic [5:0] MAX_DIST_RST = 6'd18;

    localparam logic [2:0] KIND_ADD_PART = 3'd0;
    localparam logic [2:0] KIND_ADD_ANCH = 3'd1;
    localparam logic [2:0] KIND_CLEAR    = 3'd2;
    localparam logic [2:0] KIND_SEARCH   = 3'd3;
    localparam logic [2:0] KIND_WINSUM   = 3'd4;

    localparam logic CFG_LOAD_CAP = 1'b0;
    localparam logic CFG_MAX_DIST = 1'b1;

    localparam logic [14:0] SUM_MAX = 15'd32767;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [5:0] start_distance;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] cell_index;
        logic [5:0]  ring_distance;
        logic [7:0]  cell_load;
        logic [14:0] window_sum;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture item, reset search/sum state
        logic clr_step;    // write zero at sweep address
        logic clr_start;   // reset sweep address
        logic upd_write;   // read-modify-write for add items
        logic pt_start;    // restart point walk on current ring
        logic pt_issue;    // issue read of current point and advance
        logic ring_next;   // move to next ring
        logic out_load;    // capture result
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic pt_last;     // current point is last of the walk
        logic have;
        logic give_up;     // next ring would reach limit
    } dp_sts_t;
endpackage
`default_nettype wire

// ===== sv/glcs_stream_if.sv =====
// glcs_stream_if: valid/ready channel carrying a payload of type T
// depends on nothing
`default_nettype none
interface glcs_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/grid_least_loaded_cell_search_unit.sv =====
// grid_least_loaded_cell_search_unit: top level of the grid least-loaded cell search
// depends on glcs_pkg, glcs_stream_if, glcs_ctrl, glcs_datapath
// add items read then write the item cell; clear sweeps every cell; window walks the 2*WINDOW_HALF square
// ring search: a walk over each ring's points, then the drain states; one memory read a cycle while walking
// throughput: one item in flight, next beat taken in the idle cycle after the result load
// reset: clearing pass over all GRID_SIDE^2 cells before the first beat; load_cap 73, max_distance 18
`default_nettype none
module grid_least_loaded_cell_search_unit #(
    parameter int GRID_SIDE   = glcs_pkg::GRID_SIDE_DEF,
    parameter int WINDOW_HALF = glcs_pkg::WINDOW_HALF_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    glcs_stream_if.sink             in_ch,
    glcs_stream_if.source           out_ch,
    input  wire                     cfg_we,
    input  wire                     cfg_index,
    input  wire [7:0]               cfg_data
);
    import glcs_pkg::*;

    logic [7:0] load_cap_reg;
    logic [5:0] max_dist_reg;
    dp_cmd_t    cmd;
    dp_sts_t    sts;
    item_t      item;
    result_t    res;

    // config write port, no read back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cap_reg <= LOAD_CAP_RST;
            max_dist_reg <= MAX_DIST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOAD_CAP: load_cap_reg <= cfg_data;
                CFG_MAX_DIST: max_dist_reg <= cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    assign item = in_ch.payload;

    glcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.payload.kind),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    glcs_datapath #(
        .GRID_SIDE   (GRID_SIDE),
        .WINDOW_HALF (WINDOW_HALF)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item         (item),
        .load_cap     (load_cap_reg),
        .max_distance (max_dist_reg),
        .result       (res)
    );

    assign out_ch.payload = res;
endmodule
`default_nettype wire

// ===== sv/glcs_datapath.sv =====
// glcs_datapath: cell memories, point walker, best-cell tracker and window adder
// depends on glcs_pkg
`default_nettype none
module glcs_datapath #(
    parameter int GRID_SIDE   = glcs_pkg::GRID_SIDE_DEF,
    parameter int WINDOW_HALF = glcs_pkg::WINDOW_HALF_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  glcs_pkg::dp_cmd_t      cmd,
    output glcs_pkg::dp_sts_t      sts,
    input  glcs_pkg::item_t        item,
    input  wire [7:0]              load_cap,
    input  wire [5:0]              max_distance,
    output glcs_pkg::result_t      result
);
    import glcs_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int WIN   = 2 * WINDOW_HALF;
    // signed coordinate width covers center +/- 63 offsets and the grid
    localparam int CW    = 10;
    localparam int LW    = CW + AW + 2;

    logic [7:0] cnt_mem [CELLS];
    logic       anc_mem [CELLS];

    item_t       item_reg;
    logic [5:0]  d_reg, d_next;
    logic [6:0]  dinc;
    logic [1:0]  side_reg, side_next;     // 0 top, 1 bottom, 2 left, 3 right
    logic signed [CW-1:0] off_reg, off_next;   // walk offset along side
    logic signed [CW-1:0] wy_reg, wy_next;     // window row offset
    logic [AW-1:0] clr_reg;
    logic        have_reg;
    logic [AW-1:0] best_reg;
    logic [7:0]  best_load_reg;
    logic [14:0] sum_reg;
    result_t     res_reg, res_next;

    // read pipeline
    logic          rd_v_reg;
    logic          rd_ok_reg;
    logic [AW-1:0] rd_a_reg;
    logic [7:0]    rd_cnt_reg;
    logic          rd_anc_reg;

    logic signed [CW-1:0] px, py, dd, lo, hi;
    logic signed [LW-1:0] lin;
    logic          pt_ok;
    logic [AW-1:0] pt_addr;
    logic          wsum;
    logic          last_pt;
    logic [15:0]   sum_w;

    assign wsum = (item_reg.kind == KIND_WINSUM);
    assign dd   = CW'(d_reg);
    assign dinc = {1'b0, d_reg} + 7'd1;

    always_comb
    begin
        lo = (side_reg[1]) ? -dd + CW'(1) : -dd;
        hi = (side_reg[1]) ?  dd - CW'(1) :  dd;
        if (wsum)
        begin
            lo = -CW'(WINDOW_HALF);
            hi = CW'(WINDOW_HALF - 1);
        end
        px = CW'({1'b0, item_reg.cell_x});
        py = CW'({1'b0, item_reg.cell_y});
        if (wsum)
        begin
            px = px + off_reg;
            py = py + wy_reg;
        end
        else
        begin
            case (side_reg)
                2'd0:    begin px = px + off_reg; py = py + dd; end
                2'd1:    begin px = px + off_reg; py = py - dd; end
                2'd2:    begin px = px - dd; py = py + off_reg; end
                default: begin px = px + dd; py = py + off_reg; end
            endcase
        end
        lin = LW'(px) + LW'(py) * LW'(GRID_SIDE);
        pt_ok = (lin >= 0) && (lin < LW'(CELLS));
        pt_addr = lin[AW-1:0];
        if (wsum)
            last_pt = (off_reg == hi) && (wy_reg == hi);
        else
            last_pt = (off_reg >= hi) && (side_reg == 2'd3);
    end

    // walk stepping
    always_comb
    begin
        d_next    = d_reg;
        side_next = side_reg;
        off_next  = off_reg;
        wy_next   = wy_reg;
        // only the search walks rings; add items address the item cell at d = 0
        if (cmd.load_item)
            d_next = (item.kind == KIND_SEARCH) ? item.start_distance : 6'd0;
        else if (cmd.ring_next)
            d_next = dinc[6] ? 6'd63 : dinc[5:0];
        if (cmd.pt_start)
        begin
            side_next = 2'd0;
            off_next  = wsum ? -CW'(WINDOW_HALF) : -dd;
            wy_next   = -CW'(WINDOW_HALF);
        end
        else if (cmd.pt_issue)
        begin
            if (wsum)
            begin
                if (wy_reg == hi)
                begin
                    wy_next  = lo;
                    off_next = off_reg + CW'(1);
                end
                else
                    wy_next = wy_reg + CW'(1);
            end
            else if (off_reg >= hi)
            begin
                side_next = side_reg + 2'd1;
                off_next  = (side_reg >= 2'd1) ? -dd + CW'(1) : -dd;
            end
            else
                off_next = off_reg + CW'(1);
        end
    end

    // skip empty side ranges (left/right at d = 0)
    logic skip;
    assign skip = !wsum && side_reg[1] && (d_reg == 6'd0);

    assign sum_w = {1'b0, sum_reg} + {8'd0, rd_cnt_reg};

    // memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            cnt_mem[clr_reg] <= 8'd0;
            anc_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.upd_write && rd_ok_reg)
        begin
            if (item_reg.kind == KIND_ADD_PART)
            begin
                if (rd_cnt_reg != 8'hff)
                    cnt_mem[rd_a_reg] <= rd_cnt_reg + 8'd1;
            end
            else
                anc_mem[rd_a_reg] <= 1'b1;
        end
        rd_cnt_reg <= cnt_mem[pt_addr];
        rd_anc_reg <= anc_mem[pt_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg     <= 6'd0;
            side_reg  <= 2'd0;
            off_reg   <= '0;
            wy_reg    <= '0;
            clr_reg   <= '0;
            have_reg  <= 1'b0;
            best_reg  <= '0;
            best_load_reg <= 8'd0;
            rd_v_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
            rd_a_reg  <= '0;
            sum_reg   <= '0;
            item_reg  <= '0;
        end
        else
        begin
            d_reg    <= d_next;
            side_reg <= side_next;
            off_reg  <= off_next;
            wy_reg   <= wy_next;
            if (cmd.load_item)
                item_reg <= item;
            if (cmd.clr_start)
                clr_reg <= '0;
            else if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
            rd_v_reg  <= cmd.pt_issue && !skip;
            rd_ok_reg <= pt_ok;
            rd_a_reg  <= pt_addr;
            if (cmd.load_item || cmd.ring_next)
            begin
                have_reg <= 1'b0;
                sum_reg  <= '0;
            end
            else if (rd_v_reg && rd_ok_reg)
            begin
                if (wsum)
                    sum_reg <= sum_w[15] ? SUM_MAX : sum_w[14:0];
                else if (rd_anc_reg && (rd_cnt_reg < load_cap) &&
                         (!have_reg || rd_cnt_reg < best_load_reg))
                begin
                    have_reg      <= 1'b1;
                    best_reg      <= rd_a_reg;
                    best_load_reg <= rd_cnt_reg;
                end
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        if (item_reg.kind == KIND_SEARCH)
        begin
            res_next.found         = have_reg;
            res_next.cell_index    = have_reg ? 12'(best_reg) : 12'd0;
            res_next.cell_load     = have_reg ? best_load_reg : 8'd0;
            res_next.ring_distance = d_reg;
        end
        else if (wsum)
            res_next.window_sum = sum_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            res_reg <= res_next;
    end

    assign result         = res_reg;
    assign sts.clr_last   = (clr_reg == AW'(CELLS - 1));
    assign sts.pt_last    = last_pt || skip;
    assign sts.have       = have_reg;
    assign sts.give_up    = dinc[6] || (dinc[5:0] >= max_distance);
endmodule
`default_nettype wire

// ===== sv/glcs_ctrl.sv =====
// glcs_ctrl: sequencer for item handling, ring walks, sweeps and result handoff
// depends on glcs_pkg
`default_nettype none
module glcs_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire [2:0]         in_kind,
    output logic              out_valid,
    input  wire               out_ready,
    output glcs_pkg::dp_cmd_t cmd,
    input  glcs_pkg::dp_sts_t sts
);
    import glcs_pkg::*;

    localparam logic [3:0] S_CLRINIT = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_UPDRD   = 4'd3;
    localparam logic [3:0] S_UPDWR   = 4'd4;
    localparam logic [3:0] S_CLEAR   = 4'd5;
    localparam logic [3:0] S_WALK    = 4'd6;
    localparam logic [3:0] S_DRAIN1  = 4'd7;
    localparam logic [3:0] S_DRAIN2  = 4'd8;
    localparam logic [3:0] S_RESULT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLRINIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // result register holds a waiting beat, so the input stays open
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    kind_next     = in_kind;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.pt_start = 1'b1;
                cmd.clr_start = 1'b1;
                case (kind_reg)
                    KIND_ADD_PART, KIND_ADD_ANCH: state_next = S_UPDRD;
                    KIND_CLEAR:                   state_next = S_CLEAR;
                    KIND_SEARCH, KIND_WINSUM:     state_next = S_WALK;
                    default:                      state_next = S_RESULT;
                endcase
            end
            S_UPDRD:
            begin
                // registered read of the item cell
                state_next = S_UPDWR;
            end
            S_UPDWR:
            begin
                cmd.upd_write = 1'b1;
                state_next    = S_RESULT;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_RESULT;
            end
            S_WALK:
            begin
                cmd.pt_issue = 1'b1;
                if (sts.pt_last)
                    state_next = S_DRAIN1;
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2:
            begin
                if (kind_reg == KIND_SEARCH && !sts.have)
                begin
                    cmd.ring_next = 1'b1;
                    state_next = sts.give_up ? S_RESULT : S_DISP;
                end
                else
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLRINIT;
            kind_reg  <= KIND_ADD_PART;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_grid_least_loaded_cell_search_unit.sv =====
// testbench for the grid least-loaded cell search unit: random and directed items,
// checked against an in-bench grid predictor; depends on glcs_pkg, glcs_stream_if and the rtl
`default_nettype none
module tb_grid_least_loaded_cell_search_unit;
    import glcs_pkg::*;

    localparam int SIDE  = 64;
    localparam int CELLS = SIDE * SIDE;
    localparam int WHALF = 5;
    localparam longint CYCLE_LIMIT = 64'd60000000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    glcs_stream_if #(.T(item_t))   in_ch ();
    glcs_stream_if #(.T(result_t)) out_ch ();

    grid_least_loaded_cell_search_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the grid and registers
    logic [7:0] pred_count [CELLS];
    logic       pred_anchor [CELLS];
    logic [7:0] pred_cap;
    logic [5:0] pred_maxd;

    item_t   pending_items [$];
    result_t expected_results [$];
    int      error_count = 0;
    int      results_seen = 0;
    int      searches_found = 0;
    longint  cycle_count = 0;
    bit      hold_off = 1'b0;
    bit      hold_req = 1'b0;
    int      hold_count = 0;

    task automatic report(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic enqueue_item(input item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic expect_result(input result_t r);
        expected_results = {expected_results, r};
    endtask

    function automatic int grid_index(input int x, input int y);
        int idx;
        idx = x + SIDE * y;
        if (idx < 0 || idx >= CELLS)
            return -1;
        return idx;
    endfunction

    // apply one item to the predictor grid and return its result
    function automatic result_t grid_apply(input item_t it);
        result_t r;
        int idx, d, i, k, best, cx, cy, sum;
        bit have;
        logic [7:0] best_load;
        r = '0;
        cx = it.cell_x;
        cy = it.cell_y;
        case (it.kind)
            KIND_ADD_PART:
            begin
                idx = grid_index(cx, cy);
                if (idx >= 0 && pred_count[idx] != 8'd255)
                    pred_count[idx]++;
            end
            KIND_ADD_ANCH:
            begin
                idx = grid_index(cx, cy);
                if (idx >= 0)
                    pred_anchor[idx] = 1'b1;
            end
            KIND_CLEAR:
            begin
                for (k = 0; k < CELLS; k++)
                begin
                    pred_count[k] = '0;
                    pred_anchor[k] = 1'b0;
                end
            end
            KIND_SEARCH:
            begin
                have = 1'b0;
                best = 0;
                best_load = '0;
                d = it.start_distance;
                forever
                begin
                    // top row, bottom row, left column, right column
                    for (k = 0; k < 4; k++)
                    begin
                        for (i = (k < 2) ? -d : -d + 1; i <= ((k < 2) ? d : d - 1); i++)
                        begin
                            case (k)
                                0: idx = grid_index(cx + i, cy + d);
                                1: idx = grid_index(cx + i, cy - d);
                                2: idx = grid_index(cx - d, cy + i);
                                default: idx = grid_index(cx + d, cy + i);
                            endcase
                            if (idx >= 0 && pred_anchor[idx] && pred_count[idx] < pred_cap
                                && (!have || pred_count[idx] < best_load))
                            begin
                                have = 1'b1;
                                best = idx;
                                best_load = pred_count[idx];
                            end
                        end
                    end
                    if (have)
                        break;
                    d++;
                    if (d >= pred_maxd)
                        break;
                end
                if (d > 63)
                    d = 63;
                r.found = have;
                r.cell_index = have ? best[11:0] : '0;
                r.ring_distance = d[5:0];
                r.cell_load = have ? best_load : '0;
            end
            KIND_WINSUM:
            begin
                sum = 0;
                for (i = -WHALF; i < WHALF; i++)
                    for (k = -WHALF; k < WHALF; k++)
                    begin
                        idx = grid_index(cx + i, cy + k);
                        if (idx >= 0)
                            sum += pred_count[idx];
                    end
                r.window_sum = (sum > 32767) ? SUM_MAX : sum[14:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: bursts of beats with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expect_result(grid_apply(in_ch.payload));
                void'(pending_items.pop_front());
            end
            if (in_ch.valid && !in_ch.ready)
                ; // hold the beat
            else if (pending_items.size() > 0 && gap_left == 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_items[0];
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
            begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // long receiver hold-off, counted here once requested
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_off <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            hold_off <= 1'b0;
    end

    // receiver stall pattern plus the long hold-off
    logic [7:0] stall_pattern = 8'b1011_0111;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_pattern <= 8'($urandom);
        else
            stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
        out_ch.ready <= !hold_off && (stall_pattern[0] || ($urandom_range(0, 1) != 0));
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_ch.payload.found)
                    searches_found++;
                if (out_ch.payload.found !== exp_r.found)
                    report($sformatf("found %0b exp %0b", out_ch.payload.found, exp_r.found));
                if (out_ch.payload.cell_index !== exp_r.cell_index)
                    report($sformatf("cell_index %0d exp %0d",
                                     out_ch.payload.cell_index, exp_r.cell_index));
                if (out_ch.payload.ring_distance !== exp_r.ring_distance)
                    report($sformatf("ring_distance %0d exp %0d",
                                     out_ch.payload.ring_distance, exp_r.ring_distance));
                if (out_ch.payload.cell_load !== exp_r.cell_load)
                    report($sformatf("cell_load %0d exp %0d",
                                     out_ch.payload.cell_load, exp_r.cell_load));
                if (out_ch.payload.window_sum !== exp_r.window_sum)
                    report($sformatf("window_sum %0d exp %0d",
                                     out_ch.payload.window_sum, exp_r.window_sum));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout waiting for results");
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic item_t make_item(input logic [2:0] k, input int x, input int y,
                                        input int d);
        item_t it;
        it.kind = k;
        it.cell_x = x[5:0];
        it.cell_y = y[5:0];
        it.start_distance = d[5:0];
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge clk);
        // let the block settle in idle before a register write
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LOAD_CAP)
            pred_cap = val;
        else
            pred_maxd = val[5:0];
    endtask

    // cluster population: random mix of anchors, particles, searches, window sums and random kinds
    task automatic queue_cluster(input int n);
        int j, cx, cy;
        cx = $urandom_range(0, 63);
        cy = $urandom_range(0, 63);
        for (j = 0; j < n; j++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: enqueue_item(make_item(KIND_ADD_ANCH,
                    (cx + $urandom_range(0, 16) - 8) & 63, (cy + $urandom_range(0, 16) - 8) & 63, 0));
                3, 4, 5: enqueue_item(make_item(KIND_ADD_PART,
                    (cx + $urandom_range(0, 10) - 5) & 63, (cy + $urandom_range(0, 10) - 5) & 63, 0));
                6, 7: enqueue_item(make_item(KIND_SEARCH, cx, cy,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4)));
                8: enqueue_item(make_item(KIND_WINSUM,
                    $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63)));
                default: enqueue_item(make_item(3'($urandom_range(0, 7)),
                    $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63)));
            endcase
        end
    endtask

    initial
    begin
        int j, phase;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        for (j = 0; j < CELLS; j++)
        begin
            pred_count[j] = '0;
            pred_anchor[j] = 1'b0;
        end
        pred_cap = LOAD_CAP_RST;
        pred_maxd = MAX_DIST_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, all defined kinds plus two spare codes, search start past the limit
        enqueue_item(make_item(KIND_ADD_ANCH, 63, 63, 0));
        enqueue_item(make_item(KIND_ADD_ANCH, 0, 0, 0));
        for (j = 0; j < 3; j++)
            enqueue_item(make_item(KIND_ADD_PART, 63, 63, 0));
        enqueue_item(make_item(KIND_SEARCH, 63, 63, 0));
        enqueue_item(make_item(KIND_SEARCH, 0, 0, 63));
        enqueue_item(make_item(KIND_SEARCH, 30, 30, 0));
        enqueue_item(make_item(KIND_SEARCH, 62, 0, 2));
        enqueue_item(make_item(KIND_WINSUM, 63, 63, 0));
        enqueue_item(make_item(KIND_WINSUM, 0, 0, 0));
        enqueue_item(make_item(KIND_SPARE_LO, 63, 63, 63));
        enqueue_item(make_item(KIND_SPARE_HI, 0, 0, 0));
        enqueue_item(make_item(KIND_CLEAR, 0, 0, 0));
        enqueue_item(make_item(KIND_SEARCH, 10, 10, 1));
        wait_drained();

        // saturate one cell past 255
        for (j = 0; j < 260; j++)
            enqueue_item(make_item(KIND_ADD_PART, 5, 5, 0));
        enqueue_item(make_item(KIND_ADD_ANCH, 5, 5, 0));
        enqueue_item(make_item(KIND_WINSUM, 5, 5, 0));
        wait_drained();
        write_reg(CFG_LOAD_CAP, 8'd255);
        enqueue_item(make_item(KIND_SEARCH, 5, 5, 0));
        wait_drained();
        write_reg(CFG_LOAD_CAP, 8'd0);
        enqueue_item(make_item(KIND_SEARCH, 5, 5, 0));
        wait_drained();

        // random phases over several register settings, long hold-off in the first
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_LOAD_CAP, 8'd73); write_reg(CFG_MAX_DIST, 8'd1); end
                1: begin write_reg(CFG_LOAD_CAP, 8'd3); write_reg(CFG_MAX_DIST, 8'd63); end
                2: begin write_reg(CFG_LOAD_CAP, 8'd255); write_reg(CFG_MAX_DIST, 8'd6); end
                3: begin write_reg(CFG_LOAD_CAP, 8'd1); write_reg(CFG_MAX_DIST, 8'd12); end
                4: write_reg(CFG_LOAD_CAP, 8'($urandom_range(0, 255)));
                default: write_reg(CFG_MAX_DIST, 8'($urandom_range(1, 20)));
            endcase
            if (phase == 0)
            begin
                hold_req = 1'b1;
                queue_cluster(40);
                wait (hold_count >= HOLD_CYCLES);
                hold_req = 1'b0;
            end
            for (j = 0; j < 4; j++)
                queue_cluster(40);
            if ($urandom_range(0, 1))
                enqueue_item(make_item(KIND_CLEAR, 0, 0, 0));
            wait_drained();
        end

        $display("covered %0d result beats, %0d searches found a cell, caps 0..255, limits 1..63",
                 results_seen, searches_found);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
